FILE: hw/rtl/tbp_pkg.sv
`timescale 1ns / 1ps

package tbp_pkg;

	localparam int unsigned BRANCH_PC_W = 32;

	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_BIMODAL    = 2'd0,
		MODE_GSHARE     = 2'd1,
		MODE_LOCAL      = 2'd2,
		MODE_TOURNAMENT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CTR_HOLD,
		CTR_UP,
		CTR_DOWN
	} ctr_op_t;

endpackage

FILE: hw/rtl/tbp_if.sv
`timescale 1ns / 1ps

interface tbp_branch_if import tbp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [BRANCH_PC_W-1:0] branch_pc;
	logic                   actual_taken;

	modport source (output valid, output branch_pc, output actual_taken, input ready);
	modport sink (input valid, input branch_pc, input actual_taken, output ready);
endinterface

interface tbp_result_if ();
	logic valid;
	logic ready;
	logic predicted_taken;
	logic prediction_correct;

	modport source (output valid, output predicted_taken, output prediction_correct,
		input ready);
	modport sink (input valid, input predicted_taken, input prediction_correct,
		output ready);
endinterface

FILE: hw/rtl/tournament_branch_predictor.sv
`timescale 1ns / 1ps
// Branch direction predictor: bimodal, gshare, local history or a tournament
// of gshare and local, chosen by the 2-bit mode register (cfg_we/cfg_wdata;
// the user must write it only while no item is in flight; the block does not enforce this).
// branch channel: one resolved branch per item (pc, actual direction).
// result channel: the prediction formed from the tables before this item's
// update, and whether it matched the actual direction.
// One item per cycle is accepted while branch.ready is high. The local history
// table is read as an item is accepted, the pattern tables in stage 1; in
// stage 2 their entries are written back with forwarding of the previous
// cycle's write, and the prediction is pushed into the result queue.
// After reset a clearing pass writes every table entry, one address per cycle,
// for 2**max(INDEX_BITS, HISTORY_TABLE_INDEX_BITS) addresses (65536 by default);
// branch.ready stays low until it is done. The mode register resets to bimodal.
// Results wait in a 4-item queue; when the receiver stalls, branch.ready drops
// as soon as the queue plus the items in flight fill it, and nothing is
// lost.
module tournament_branch_predictor import tbp_pkg::*; #(
	parameter int unsigned INDEX_BITS               = 16,
	parameter int unsigned GLOBAL_HISTORY_BITS      = 16,
	parameter int unsigned LOCAL_HISTORY_BITS       = 3,
	parameter int unsigned HISTORY_TABLE_INDEX_BITS = 6,
	parameter int unsigned COUNTER_BITS             = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	tbp_branch_if.sink  branch,
	tbp_result_if.source result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	localparam int unsigned IB    = INDEX_BITS;
	localparam int unsigned HTI   = HISTORY_TABLE_INDEX_BITS;
	localparam int unsigned GHB   = GLOBAL_HISTORY_BITS;
	localparam int unsigned LHB   = LOCAL_HISTORY_BITS;
	localparam int unsigned CB    = COUNTER_BITS;
	localparam int unsigned PC_W  = (IB > HTI) ? IB : HTI;
	localparam int unsigned CLR_W = PC_W;
	localparam int unsigned GX_W  = (IB > GHB) ? IB : GHB;
	localparam int unsigned LX_W  = (IB > LHB) ? IB : LHB;
	localparam logic [CB-1:0] CNT_WEAK_NT = CB'((2 ** CB) / 2 - 1);

	// configuration
	mode_t mode_q;
	logic  uses_global;
	logic  uses_local;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BIMODAL;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	assign uses_global = (mode_q == MODE_GSHARE) || (mode_q == MODE_TOURNAMENT);
	assign uses_local  = (mode_q == MODE_LOCAL) || (mode_q == MODE_TOURNAMENT);

	// clearing pass
	logic             clr_busy_q;
	logic [CLR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CLR_W'(1);
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// input acceptance
	logic                valid_s1;
	logic                valid_s2;
	logic [OQ_CNT_W-1:0] ofq_cnt_q;
	logic [OQ_CNT_W-1:0] occupancy;
	logic                accept;

	assign occupancy = ofq_cnt_q + OQ_CNT_W'(valid_s1) + OQ_CNT_W'(valid_s2);
	assign branch.ready = !clr_busy_q && (occupancy < OQ_CNT_W'(OQ_DEPTH));
	assign accept = branch.valid && branch.ready;

	// stage 1: local history available, indexes formed, pattern tables read
	logic [PC_W-1:0] pc_s1;
	logic            taken_s1;
	logic [LHB-1:0]  lht_rdata;
	logic [LHB-1:0]  lh_s1;
	logic            lw_v_q;
	logic [HTI-1:0]  lw_addr_q;
	logic [LHB-1:0]  lw_data_q;
	logic            lht_we_item;
	logic [LHB:0]    lh_shift;
	logic [LHB-1:0]  lh_new;
	logic [GHB-1:0]  ghr_q;
	logic [GHB:0]    ghr_shift;
	logic [GX_W-1:0] ghr_ext;
	logic [LX_W-1:0] lh_ext;
	logic [IB-1:0]   bim_idx_s1;
	logic [IB-1:0]   gsh_idx_s1;
	logic [IB-1:0]   loc_idx_s1;

	assign lh_s1 = (lw_v_q && lw_addr_q == pc_s1[HTI-1:0]) ? lw_data_q : lht_rdata;
	assign lht_we_item = valid_s1 && uses_local;
	assign lh_shift = {lh_s1, taken_s1};
	assign lh_new = lh_shift[LHB-1:0];
	assign ghr_shift = {ghr_q, taken_s1};
	assign ghr_ext = GX_W'(ghr_q);
	assign lh_ext = LX_W'(lh_s1);
	assign bim_idx_s1 = pc_s1[IB-1:0];
	assign gsh_idx_s1 = pc_s1[IB-1:0] ^ ghr_ext[IB-1:0];
	assign loc_idx_s1 = pc_s1[IB-1:0] ^ lh_ext[IB-1:0];

	tbp_ram #(.WIDTH(LHB), .DEPTH(2 ** HTI)) u_lht (
		.clk   (clk),
		.we    (clr_busy_q || lht_we_item),
		.waddr (clr_busy_q ? clr_addr_q[HTI-1:0] : pc_s1[HTI-1:0]),
		.wdata (clr_busy_q ? '0 : lh_new),
		.raddr (branch.branch_pc[HTI-1:0]),
		.rdata (lht_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			lw_v_q   <= 1'b0;
			ghr_q    <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			lw_v_q   <= lht_we_item;
			if (valid_s1 && uses_global) begin
				ghr_q <= ghr_shift[GHB-1:0];
			end
		end
	end

	// stage 2: counters available, prediction, write-back
	logic            taken_s2;
	logic [IB-1:0]   bim_idx_s2;
	logic [IB-1:0]   gsh_idx_s2;
	logic [IB-1:0]   loc_idx_s2;
	logic [CB-1:0]   bim_rdata;
	logic [CB-1:0]   gsh_rdata;
	logic [CB-1:0]   loc_rdata;
	logic            bw_v_q;
	logic            gw_v_q;
	logic            cw_v_q;
	logic [IB-1:0]   bw_addr_q;
	logic [IB-1:0]   gw_addr_q;
	logic [IB-1:0]   cw_addr_q;
	logic [CB-1:0]   bw_data_q;
	logic [CB-1:0]   gw_data_q;
	logic [CB-1:0]   cw_data_q;
	logic [CB-1:0]   bim_cnt;
	logic [CB-1:0]   gsh_cnt;
	logic [CB-1:0]   loc_cnt;
	logic [CB-1:0]   bim_next;
	logic [CB-1:0]   gsh_next;
	logic [CB-1:0]   loc_next;
	logic [CB-1:0]   chooser_q;
	logic [CB-1:0]   chooser_next;
	logic            bim_taken;
	logic            gsh_taken;
	logic            loc_taken;
	logic            chooser_gshare;
	ctr_op_t         dir_op;
	ctr_op_t         chooser_op;
	logic            gsh_ok;
	logic            loc_ok;
	logic            pred;
	logic            bim_we_item;
	logic            gsh_we_item;
	logic            loc_we_item;

	always_ff @(posedge clk) begin
		pc_s1      <= branch.branch_pc[PC_W-1:0];
		taken_s1   <= branch.actual_taken;
		lw_addr_q  <= pc_s1[HTI-1:0];
		lw_data_q  <= lh_new;
		taken_s2   <= taken_s1;
		bim_idx_s2 <= bim_idx_s1;
		gsh_idx_s2 <= gsh_idx_s1;
		loc_idx_s2 <= loc_idx_s1;
		bw_addr_q  <= bim_idx_s2;
		gw_addr_q  <= gsh_idx_s2;
		cw_addr_q  <= loc_idx_s2;
		bw_data_q  <= bim_next;
		gw_data_q  <= gsh_next;
		cw_data_q  <= loc_next;
	end

	assign bim_we_item = valid_s2 && (mode_q == MODE_BIMODAL);
	assign gsh_we_item = valid_s2 && uses_global;
	assign loc_we_item = valid_s2 && uses_local;

	tbp_ram #(.WIDTH(CB), .DEPTH(2 ** IB)) u_bim_pht (
		.clk   (clk),
		.we    (clr_busy_q || bim_we_item),
		.waddr (clr_busy_q ? clr_addr_q[IB-1:0] : bim_idx_s2),
		.wdata (clr_busy_q ? CNT_WEAK_NT : bim_next),
		.raddr (bim_idx_s1),
		.rdata (bim_rdata)
	);

	tbp_ram #(.WIDTH(CB), .DEPTH(2 ** IB)) u_gsh_pht (
		.clk   (clk),
		.we    (clr_busy_q || gsh_we_item),
		.waddr (clr_busy_q ? clr_addr_q[IB-1:0] : gsh_idx_s2),
		.wdata (clr_busy_q ? CNT_WEAK_NT : gsh_next),
		.raddr (gsh_idx_s1),
		.rdata (gsh_rdata)
	);

	tbp_ram #(.WIDTH(CB), .DEPTH(2 ** IB)) u_loc_pht (
		.clk   (clk),
		.we    (clr_busy_q || loc_we_item),
		.waddr (clr_busy_q ? clr_addr_q[IB-1:0] : loc_idx_s2),
		.wdata (clr_busy_q ? CNT_WEAK_NT : loc_next),
		.raddr (loc_idx_s1),
		.rdata (loc_rdata)
	);

	assign bim_cnt = (bw_v_q && bw_addr_q == bim_idx_s2) ? bw_data_q : bim_rdata;
	assign gsh_cnt = (gw_v_q && gw_addr_q == gsh_idx_s2) ? gw_data_q : gsh_rdata;
	assign loc_cnt = (cw_v_q && cw_addr_q == loc_idx_s2) ? cw_data_q : loc_rdata;

	assign dir_op = taken_s2 ? CTR_UP : CTR_DOWN;

	tbp_ctr #(.WIDTH(CB)) u_bim_ctr (
		.cnt      (bim_cnt),
		.op       (dir_op),
		.cnt_next (bim_next),
		.taken    (bim_taken)
	);

	tbp_ctr #(.WIDTH(CB)) u_gsh_ctr (
		.cnt      (gsh_cnt),
		.op       (dir_op),
		.cnt_next (gsh_next),
		.taken    (gsh_taken)
	);

	tbp_ctr #(.WIDTH(CB)) u_loc_ctr (
		.cnt      (loc_cnt),
		.op       (dir_op),
		.cnt_next (loc_next),
		.taken    (loc_taken)
	);

	assign gsh_ok = gsh_taken == taken_s2;
	assign loc_ok = loc_taken == taken_s2;

	always_comb begin
		chooser_op = CTR_HOLD;
		if (gsh_ok && !loc_ok) begin
			chooser_op = CTR_UP;
		end else if (loc_ok && !gsh_ok) begin
			chooser_op = CTR_DOWN;
		end
	end

	tbp_ctr #(.WIDTH(CB)) u_chooser (
		.cnt      (chooser_q),
		.op       (chooser_op),
		.cnt_next (chooser_next),
		.taken    (chooser_gshare)
	);

	always_comb begin
		unique case (mode_q)
			MODE_BIMODAL:    pred = bim_taken;
			MODE_GSHARE:     pred = gsh_taken;
			MODE_LOCAL:      pred = loc_taken;
			MODE_TOURNAMENT: pred = chooser_gshare ? gsh_taken : loc_taken;
			default:         pred = bim_taken;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_v_q    <= 1'b0;
			gw_v_q    <= 1'b0;
			cw_v_q    <= 1'b0;
			chooser_q <= CNT_WEAK_NT;
		end else begin
			bw_v_q <= bim_we_item;
			gw_v_q <= gsh_we_item;
			cw_v_q <= loc_we_item;
			if (valid_s2 && mode_q == MODE_TOURNAMENT) begin
				chooser_q <= chooser_next;
			end
		end
	end

	// result queue
	logic [1:0]          ofq_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] ofq_wr_q;
	logic [OQ_PTR_W-1:0] ofq_rd_q;
	logic                ofq_pop;

	assign result.valid = ofq_cnt_q != '0;
	assign result.predicted_taken = ofq_mem[ofq_rd_q][1];
	assign result.prediction_correct = ofq_mem[ofq_rd_q][0];
	assign ofq_pop = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			ofq_mem[ofq_wr_q] <= {pred, pred == taken_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofq_wr_q  <= '0;
			ofq_rd_q  <= '0;
			ofq_cnt_q <= '0;
		end else begin
			if (valid_s2) begin
				ofq_wr_q <= ofq_wr_q + OQ_PTR_W'(1);
			end
			if (ofq_pop) begin
				ofq_rd_q <= ofq_rd_q + OQ_PTR_W'(1);
			end
			ofq_cnt_q <= ofq_cnt_q + OQ_CNT_W'(valid_s2) - OQ_CNT_W'(ofq_pop);
		end
	end

	// checks
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !branch.ready)
		else $error("item accepted during clearing pass");

	a_queue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue credit exceeded");

	a_ghr_only_on_global: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && uses_global) |=> $stable(ghr_q))
		else $error("global history changed without a global-mode item");

endmodule

FILE: hw/rtl/tbp_ram.sv
`timescale 1ns / 1ps

module tbp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/tbp_ctr.sv
`timescale 1ns / 1ps

module tbp_ctr import tbp_pkg::*; #(
	parameter int unsigned WIDTH = 2
) (
	input  logic [WIDTH-1:0] cnt,
	input  ctr_op_t          op,
	output logic [WIDTH-1:0] cnt_next,
	output logic             taken
);

	localparam logic [WIDTH-1:0] WEAK_NT = WIDTH'((2 ** WIDTH) / 2 - 1);
	localparam logic [WIDTH-1:0] CNT_MAX = '1;

	assign taken = cnt > WEAK_NT;

	always_comb begin
		cnt_next = cnt;
		case (op)
			CTR_UP: begin
				if (cnt != CNT_MAX) begin
					cnt_next = cnt + WIDTH'(1);
				end
			end
			CTR_DOWN: begin
				if (cnt != '0) begin
					cnt_next = cnt - WIDTH'(1);
				end
			end
			default: begin
				cnt_next = cnt;
			end
		endcase
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tbp_pkg::*;

	localparam int unsigned IDX_W  = 16;
	localparam int unsigned GHR_W  = 16;
	localparam int unsigned LHR_W  = 3;
	localparam int unsigned SLOT_W = 6;
	localparam bit [1:0]    WEAK_NT = 2'd1;
	localparam bit [1:0]    CTR_MAX = 2'd3;

	typedef struct packed {
		bit taken;
		bit correct;
	} outcome_t;

	class branch_scoreboard;
		mode_t             mode;
		bit [1:0]          bim_ctr [1 << IDX_W];
		bit [1:0]          gsh_ctr [1 << IDX_W];
		bit [1:0]          loc_ctr [1 << IDX_W];
		bit [LHR_W-1:0]    loc_hist [1 << SLOT_W];
		bit [GHR_W-1:0]    ghist;
		bit [1:0]          chooser;
		outcome_t          outcome_q [$];
		int                errors;

		function new();
			mode = MODE_BIMODAL;
			foreach (bim_ctr[i]) begin
				bim_ctr[i] = WEAK_NT;
				gsh_ctr[i] = WEAK_NT;
				loc_ctr[i] = WEAK_NT;
			end
			foreach (loc_hist[i])
				loc_hist[i] = '0;
			ghist   = '0;
			chooser = WEAK_NT;
			errors  = 0;
		endfunction

		function bit says_taken(bit [1:0] c);
			return c > WEAK_NT;
		endfunction

		function bit [1:0] bump(bit [1:0] c, bit up);
			if (up)
				return (c < CTR_MAX) ? c + 2'd1 : c;
			return (c > 2'd0) ? c - 2'd1 : c;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function void note_branch(logic [BRANCH_PC_W-1:0] pc, bit t);
			bit [IDX_W-1:0]  bi;
			bit [IDX_W-1:0]  gi;
			bit [IDX_W-1:0]  li;
			bit [SLOT_W-1:0] slot;
			bit              pg;
			bit              pl;
			bit              pred;
			outcome_t        o;
			bi   = pc[IDX_W-1:0];
			gi   = pc[IDX_W-1:0] ^ ghist;
			slot = pc[SLOT_W-1:0];
			li   = pc[IDX_W-1:0] ^ IDX_W'(loc_hist[slot]);
			pg   = says_taken(gsh_ctr[gi]);
			pl   = says_taken(loc_ctr[li]);
			case (mode)
				MODE_BIMODAL: begin
					pred = says_taken(bim_ctr[bi]);
					bim_ctr[bi] = bump(bim_ctr[bi], t);
				end
				MODE_GSHARE: begin
					pred = pg;
				end
				MODE_LOCAL: begin
					pred = pl;
				end
				default: begin
					pred = says_taken(chooser) ? pg : pl;
					if (pg == t && pl != t)
						chooser = bump(chooser, 1'b1);
					else if (pl == t && pg != t)
						chooser = bump(chooser, 1'b0);
				end
			endcase
			if (mode == MODE_GSHARE || mode == MODE_TOURNAMENT) begin
				gsh_ctr[gi] = bump(gsh_ctr[gi], t);
				ghist = {ghist[GHR_W-2:0], t};
			end
			if (mode == MODE_LOCAL || mode == MODE_TOURNAMENT) begin
				loc_ctr[li] = bump(loc_ctr[li], t);
				loc_hist[slot] = {loc_hist[slot][LHR_W-2:0], t};
			end
			o.taken   = pred;
			o.correct = (pred == t);
			outcome_q.push_back(o);
		endfunction

		function void check_result(logic p, logic c);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				$error("result with no branch outstanding: predicted_taken %0d", p);
				errors++;
				return;
			end
			o = outcome_q.pop_front();
			if (p !== o.taken) begin
				$error("predicted_taken expected %0d actual %0d", o.taken, p);
				errors++;
			end
			if (c !== o.correct) begin
				$error("prediction_correct expected %0d actual %0d", o.correct, c);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	tbp_branch_if branch_ch ();
	tbp_result_if result_ch ();

	tournament_branch_predictor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.branch    (branch_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	branch_scoreboard sb = new();

	int unsigned src_odds;
	int unsigned snk_odds;

	logic [BRANCH_PC_W-1:0] hot_pc [12];
	bit [5:0]               hot_pat [12];
	int                     hot_len [12];
	int                     hot_pos [12];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
				sb.check_result(result_ch.predicted_taken, result_ch.prediction_correct);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (snk_odds != 0 && $urandom_range(snk_odds - 1, 0) == 0) begin
				hold = $urandom_range(14, 1) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_branch(input logic [BRANCH_PC_W-1:0] pc, input bit t);
		int gap;
		if (src_odds != 0 && $urandom_range(src_odds - 1, 0) == 0) begin
			gap = $urandom_range(14, 1);
			branch_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		branch_ch.valid        <= 1'b1;
		branch_ch.branch_pc    <= pc;
		branch_ch.actual_taken <= t;
		do
			@(posedge clk);
		while (branch_ch.ready !== 1'b1);
		sb.note_branch(pc, t);
	endtask

	task automatic load_mode(input mode_t m);
		branch_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	task automatic random_run(input mode_t m, input int count, input bit calm);
		int                     r;
		int                     k;
		logic [BRANCH_PC_W-1:0] pc;
		bit                     t;
		load_mode(m);
		if (calm) begin
			src_odds = 0;
			snk_odds = 0;
		end else begin
			r = $urandom_range(2, 0);
			src_odds = (r == 0) ? 0 : (r == 1) ? 4 : 10;
			r = $urandom_range(2, 0);
			snk_odds = (r == 0) ? 0 : (r == 1) ? 4 : 10;
		end
		repeat (count) begin
			r = $urandom_range(99, 0);
			if (r < 75) begin
				k = $urandom_range(11, 0);
				pc = hot_pc[k];
				t = hot_pat[k][hot_pos[k]];
				hot_pos[k] = (hot_pos[k] + 1) % hot_len[k];
				if (r < 4)
					t = ~t;
			end else begin
				pc = $urandom;
				t = 1'($urandom_range(1, 0));
			end
			push_branch(pc, t);
		end
	endtask

	initial begin
		mode_t plan [10];
		int    n;
		plan = '{MODE_TOURNAMENT, MODE_GSHARE, MODE_LOCAL, MODE_TOURNAMENT, MODE_BIMODAL,
			MODE_LOCAL, MODE_TOURNAMENT, MODE_GSHARE, MODE_BIMODAL, MODE_TOURNAMENT};
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= MODE_BIMODAL;
		branch_ch.valid        <= 1'b0;
		branch_ch.branch_pc    <= '0;
		branch_ch.actual_taken <= 1'b0;
		src_odds = 6;
		snk_odds = 6;
		for (int i = 0; i < 12; i++) begin
			hot_pc[i] = $urandom;
			if (i >= 6)
				hot_pc[i][5:0] = hot_pc[i - 6][5:0];
			hot_pat[i] = 6'($urandom);
			hot_len[i] = $urandom_range(6, 1);
			hot_pos[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// bimodal: upward saturation, pc aliasing on the low index bits
		load_mode(MODE_BIMODAL);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'hFFFF_FFFF, 1'b0);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'h0001_0000, 1'b0);

		// gshare: history longer than the item stream, index masked to table size
		load_mode(MODE_GSHARE);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'h0000_0000, 1'b1);
		push_branch(32'hFFFF_FFFF, 1'b1);
		push_branch(32'h0000_FFFF, 1'b0);
		push_branch(32'h0001_0000, 1'b1);

		// local: two pcs sharing one history slot
		load_mode(MODE_LOCAL);
		push_branch(32'h0000_0005, 1'b1);
		push_branch(32'h0000_0005, 1'b0);
		push_branch(32'h0000_0005, 1'b1);
		push_branch(32'h0000_0005, 1'b1);
		push_branch(32'h0000_0045, 1'b1);
		push_branch(32'hFFFF_FFFF, 1'b0);

		// bimodal table must survive the other modes
		load_mode(MODE_BIMODAL);
		push_branch(32'h0000_0000, 1'b0);

		load_mode(MODE_TOURNAMENT);
		push_branch(32'h0000_0003, 1'b1);
		push_branch(32'h0000_0003, 1'b1);
		push_branch(32'h0000_0003, 1'b0);
		push_branch(32'h0000_0003, 1'b1);
		push_branch(32'h0000_0003, 1'b1);
		push_branch(32'h0000_0003, 1'b0);

		foreach (plan[i])
			random_run(plan[i], 192, i == 9);

		branch_ch.valid <= 1'b0;
		n = 0;
		while (sb.pending() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: tournament_branch_predictor.f
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_if.sv
hw/rtl/tbp_ram.sv
hw/rtl/tbp_ctr.sv
hw/rtl/tournament_branch_predictor.sv
tb/sv/tb.sv
